/* sv/spk_pkg.sv */
`timescale 1ns / 1ps

package spk_pkg;

  localparam int WORD_W     = 64;
  localparam int ROT_X      = 8;
  localparam int ROT_Y      = 3;
  localparam int CFG_INDEX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = CFG_INDEX_W'(1);

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  op;
    word_t block_low;
    word_t block_high;
  } item_t;

  typedef struct packed {
    word_t result_low;
    word_t result_high;
  } result_t;

  // Operation of the shared round unit
  typedef enum logic [1:0] {
    RND_HOLD = 2'd0,
    RND_LOAD = 2'd1,
    RND_FWD  = 2'd2,
    RND_INV  = 2'd3
  } rnd_op_t;

  typedef struct packed {
    rnd_op_t op;
  } rnd_ctl_t;

  // Movement of the round key ring
  typedef enum logic [1:0] {
    RING_HOLD = 2'd0,
    RING_FWD  = 2'd1,
    RING_BACK = 2'd2
  } ring_op_t;

  typedef struct packed {
    ring_op_t op;
  } ring_ctl_t;

  function automatic word_t rotr(input word_t v, input int s);
    rotr = (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic word_t rotl(input word_t v, input int s);
    rotl = (v << s) | (v >> (WORD_W - s));
  endfunction

endpackage

/* sv/spk_key_cell.sv */
`timescale 1ns / 1ps

module spk_key_cell
  import spk_pkg::*;
(
  input  logic      clk,
  input  ring_ctl_t ctl,
  input  word_t     from_next,
  input  word_t     from_prev,
  output word_t     key
);

  word_t key_q;

  always_ff @(posedge clk) begin
    case (ctl.op)
      RING_FWD:  key_q <= from_next;
      RING_BACK: key_q <= from_prev;
      default:   key_q <= key_q;
    endcase
  end

  assign key = key_q;

endmodule

/* sv/spk_round.sv */
`timescale 1ns / 1ps

module spk_round
  import spk_pkg::*;
(
  input  logic     clk,
  input  rnd_ctl_t ctl,
  input  word_t    load_x,
  input  word_t    load_y,
  input  word_t    key,
  output word_t    x,
  output word_t    y
);

  word_t x_q;
  word_t y_q;
  word_t fwd_x;
  word_t fwd_y;
  word_t inv_x;
  word_t inv_y;

  // Forward round: rotate, add, mix key, then fold x into y
  always_comb begin
    fwd_x = (rotr(x_q, ROT_X) + y_q) ^ key;
    fwd_y = rotl(y_q, ROT_Y) ^ fwd_x;
  end

  // Inverse round: undo the forward steps in reverse order
  always_comb begin
    inv_y = rotr(y_q ^ x_q, ROT_Y);
    inv_x = rotl((x_q ^ key) - inv_y, ROT_X);
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      RND_LOAD: begin
        x_q <= load_x;
        y_q <= load_y;
      end
      RND_FWD: begin
        x_q <= fwd_x;
        y_q <= fwd_y;
      end
      RND_INV: begin
        x_q <= inv_x;
        y_q <= inv_y;
      end
      default: begin
        x_q <= x_q;
        y_q <= y_q;
      end
    endcase
  end

  assign x = x_q;
  assign y = y_q;

endmodule

/* sv/speck128_block_cipher_unit.sv */
`timescale 1ns / 1ps

// Speck 128/128 block cipher, one round per clock. A block is taken when
// start is high and busy is low; it then runs all ROUNDS rounds in the
// single round unit, and the processed block appears on result for exactly
// one cycle with result_valid high, in the cycle after the last round. A
// new block may be started in the very cycle the result is shown. The
// receiver cannot stall: a result not taken in its cycle is gone. Round
// keys live in a ring of ROUNDS key cells that rotates one step per round,
// forwards for encryption and backwards for decryption, so the key for each
// round is always at a fixed end of the ring. Writing key register 0 or 1
// reruns the key schedule through the same round unit: a set-up state
// (ST_PREP) and then the expansion state (ST_EXPAND), during which busy
// is high and cfg_ready is low. Reset runs the same schedule for the
// all-zero key. Writes to other register indexes are taken and dropped.
module speck128_block_cipher_unit
  import spk_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   result_valid,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  word_t                  cfg_data
);

  localparam int CNT_W = $clog2(ROUNDS);
  localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUNDS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_EXPAND = 4'b0100,
    ST_RUN    = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             decrypt;
  logic             result_valid_q;
  word_t            key_low;
  word_t            key_high;

  logic      accept;
  logic      cfg_write;
  rnd_ctl_t  rnd_ctl;
  ring_ctl_t ring_ctl;
  word_t     load_x;
  word_t     load_y;
  word_t     round_key;
  word_t     x;
  word_t     y;
  word_t     ring_tail_in;
  word_t     ring_key [ROUNDS];

  assign busy      = (state != ST_IDLE);
  // Give a start the cycle when both arrive together
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end else if (cfg_write &&
                     (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP:   state_next = ST_EXPAND;
      ST_EXPAND: if (count == LAST_ROUND) state_next = ST_IDLE;
      ST_RUN:    if (count == LAST_ROUND) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_PREP;
      count          <= '0;
      result_valid_q <= 1'b0;
      key_low        <= '0;
      key_high       <= '0;
      decrypt        <= 1'b0;
    end else begin
      state          <= state_next;
      result_valid_q <= (state == ST_RUN) && (count == LAST_ROUND);
      if (state == ST_EXPAND || state == ST_RUN) begin
        count <= count + CNT_W'(1);
      end else begin
        count <= '0;
      end
      if (accept) begin
        decrypt <= item.op;
      end
      if (cfg_write && !accept) begin
        if (cfg_index == REG_KEY_LOW) key_low <= cfg_data;
        if (cfg_index == REG_KEY_HIGH) key_high <= cfg_data;
      end
    end
  end

  // Round unit control: load a block or the key words, then step
  always_comb begin
    rnd_ctl.op = RND_HOLD;
    load_x     = item.block_high;
    load_y     = item.block_low;
    round_key  = ring_key[0];
    case (state)
      ST_IDLE: if (accept) rnd_ctl.op = RND_LOAD;
      ST_PREP: begin
        rnd_ctl.op = RND_LOAD;
        load_x     = key_high;
        load_y     = key_low;
      end
      ST_EXPAND: begin
        rnd_ctl.op = RND_FWD;
        // The schedule uses the round index as its key
        round_key  = WORD_W'(count);
      end
      ST_RUN: begin
        rnd_ctl.op = decrypt ? RND_INV : RND_FWD;
        round_key  = decrypt ? ring_key[ROUNDS-1] : ring_key[0];
      end
      default: rnd_ctl.op = RND_HOLD;
    endcase
  end

  // Ring control: fill from the schedule, rotate while a block runs
  always_comb begin
    ring_ctl.op  = RING_HOLD;
    ring_tail_in = ring_key[0];
    case (state)
      ST_EXPAND: begin
        ring_ctl.op  = RING_FWD;
        ring_tail_in = y;
      end
      ST_RUN:  ring_ctl.op = decrypt ? RING_BACK : RING_FWD;
      default: ring_ctl.op = RING_HOLD;
    endcase
  end

  spk_round u_round (
    .clk    (clk),
    .ctl    (rnd_ctl),
    .load_x (load_x),
    .load_y (load_y),
    .key    (round_key),
    .x      (x),
    .y      (y)
  );

  for (genvar i = 0; i < ROUNDS; i++) begin : g_ring
    word_t from_next;
    word_t from_prev;

    if (i == ROUNDS - 1) begin : g_tail
      assign from_next = ring_tail_in;
    end else begin : g_mid_n
      assign from_next = ring_key[i+1];
    end

    if (i == 0) begin : g_head
      assign from_prev = ring_key[ROUNDS-1];
    end else begin : g_mid_p
      assign from_prev = ring_key[i-1];
    end

    spk_key_cell u_cell (
      .clk       (clk),
      .ctl       (ring_ctl),
      .from_next (from_next),
      .from_prev (from_prev),
      .key       (ring_key[i])
    );
  end

  // Hold the finished block on the round unit's registers for its cycle
  assign result_valid       = result_valid_q;
  assign result.result_low  = y;
  assign result.result_high = x;

endmodule

/* dv/speck128_block_cipher_unit_tb.sv */
`timescale 1ns / 1ps

module speck128_block_cipher_unit_tb;
  import spk_pkg::*;

  localparam int SPK_ROUNDS = 32;

  // Operation select carried in the op bit of a block transaction
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Register indexes that decode to nothing; writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = '1;

  localparam int PHASES       = 8;
  localparam int PHASE_BLOCKS = 175;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  // Published Speck128/128 vector: key, plaintext and ciphertext words
  localparam word_t KAT_KEY_LOW  = 64'h0706050403020100;
  localparam word_t KAT_KEY_HIGH = 64'h0f0e0d0c0b0a0908;
  localparam word_t KAT_PT_LOW   = 64'h7469206564616d20;
  localparam word_t KAT_PT_HIGH  = 64'h6c61766975716520;
  localparam word_t KAT_CT_LOW   = 64'h7860fedf5c570d18;
  localparam word_t KAT_CT_HIGH  = 64'ha65d985179783265;

  typedef enum logic {ROW_KEY, ROW_BLOCK} row_kind_t;

  // One line of the directed stimulus table
  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   index;
    word_t                    data;
    item_t                    blk;
    bit                       typed;
    result_t                  want;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  item_t                  item;
  logic                   result_valid;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  word_t                  cfg_data;

  // Our own copy of the key registers and the expanded schedule
  word_t   key_lo_w;
  word_t   key_hi_w;
  word_t   round_key [SPK_ROUNDS];

  // Processed blocks still owed by the block, oldest first
  result_t awaited_blocks [$];
  row_t    directed_rows [$];

  int errors = 0;
  int n_encrypt;
  int n_decrypt;
  int n_round_trips;
  int n_key_loads;
  int idle_cycles = 0;

  speck128_block_cipher_unit #(
    .ROUNDS(SPK_ROUNDS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Expand the round keys from the current key words: the key schedule is
  // the cipher round itself, with the round number standing in as the key.
  function automatic void speck_schedule();
    word_t k_w;
    word_t l_w;
    k_w = key_lo_w;
    l_w = key_hi_w;
    for (int r = 0; r < SPK_ROUNDS; r++) begin
      round_key[r] = k_w;
      if (r < SPK_ROUNDS - 1) begin
        l_w = ({l_w[7:0], l_w[63:8]} + k_w) ^ word_t'(r);
        k_w = {k_w[60:0], k_w[63:61]} ^ l_w;
      end
    end
  endfunction

  // Encrypt or decrypt one block under the current schedule
  function automatic result_t speck_process(item_t it);
    word_t   x;
    word_t   y;
    result_t r;
    x = it.block_high;
    y = it.block_low;
    if (it.op == OP_DECRYPT) begin
      // undo the rounds last key first
      for (int i = SPK_ROUNDS - 1; i >= 0; i--) begin
        y = y ^ x;
        y = {y[2:0], y[63:3]};
        x = x ^ round_key[i];
        x = x - y;
        x = {x[55:0], x[63:56]};
      end
    end else begin
      for (int i = 0; i < SPK_ROUNDS; i++) begin
        x = ({x[7:0], x[63:8]} + y) ^ round_key[i];
        y = {y[60:0], y[63:61]} ^ x;
      end
    end
    r.result_low  = y;
    r.result_high = x;
    return r;
  endfunction

  // Words biased towards the corners: all zeros, all ones, walking bits
  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, 63);
      3: w = ~(word_t'(1) << $urandom_range(0, 63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic void add_key(logic [CFG_INDEX_W-1:0] idx, word_t val);
    row_t row;
    row = '{kind: ROW_KEY, index: idx, data: val, blk: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_block(logic op, word_t lo, word_t hi);
    row_t row;
    row = '{kind: ROW_BLOCK, index: '0, data: '0,
            blk: '{op: op, block_low: lo, block_high: hi}, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  // A block whose answer is known outright rather than predicted
  function automatic void add_known(logic op, word_t lo, word_t hi,
                                    word_t want_lo, word_t want_hi);
    row_t row;
    row = '{kind: ROW_BLOCK, index: '0, data: '0,
            blk: '{op: op, block_low: lo, block_high: hi}, typed: 1'b1,
            want: '{result_low: want_lo, result_high: want_hi}};
    directed_rows.push_back(row);
  endfunction

  // Offer one block and hold it until the block takes it; queue what
  // should come back. Call on a rising edge.
  task automatic send_block(input item_t it, input bit typed, input result_t want,
                            output result_t pred);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pred = typed ? want : speck_process(it);
    awaited_blocks.push_back(pred);
    if (it.op == OP_DECRYPT) n_decrypt++;
    else n_encrypt++;
  endtask

  // Drop start and wait until every owed result has come back. As every
  // block yields exactly one result, an empty queue means no block is in flight.
  task automatic settle();
    start <= 1'b0;
    while (awaited_blocks.size() != 0) @(posedge clk);
  endtask

  // One register write transaction; the schedule is rerun only for a
  // register that exists. Drops cfg_valid again after the write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_LOW) begin
      key_lo_w = val;
      speck_schedule();
      n_key_loads++;
    end else if (idx == REG_KEY_HIGH) begin
      key_hi_w = val;
      speck_schedule();
      n_key_loads++;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Check each strobed result against the oldest owed block. Results are
  // sampled at the edge that ends their cycle.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (awaited_blocks.size() == 0) begin
        $error("result with nothing owed: result_low %h result_high %h",
               result.result_low, result.result_high);
        errors++;
      end else begin
        want = awaited_blocks.pop_front();
        if (result.result_low !== want.result_low) begin
          $error("result_low: expected %h, got %h", want.result_low, result.result_low);
          errors++;
        end
        if (result.result_high !== want.result_high) begin
          $error("result_high: expected %h, got %h", want.result_high, result.result_high);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction of any kind completes
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int      burst_left;
    int      gap;
    bit      have_prev;
    item_t   blk;
    item_t   prev_blk;
    result_t pred;
    result_t prev_pred;

    n_encrypt     = 0;
    n_decrypt     = 0;
    n_round_trips = 0;
    n_key_loads   = 0;
    have_prev     = 1'b0;
    burst_left    = 0;

    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    // Reset leaves the all-zero key expanded
    key_lo_w = '0;
    key_hi_w = '0;
    speck_schedule();

    // Directed table. Zero key straight out of reset, corners of the block
    add_block(OP_ENCRYPT, '0, '0);
    add_block(OP_ENCRYPT, '1, '1);
    add_block(OP_DECRYPT, '0, '0);
    add_block(OP_DECRYPT, '1, '1);
    add_block(OP_ENCRYPT, '0, '1);
    add_block(OP_DECRYPT, '1, '0);
    // Published vector, both ways
    add_key(REG_KEY_LOW, KAT_KEY_LOW);
    add_key(REG_KEY_HIGH, KAT_KEY_HIGH);
    add_known(OP_ENCRYPT, KAT_PT_LOW, KAT_PT_HIGH, KAT_CT_LOW, KAT_CT_HIGH);
    add_known(OP_DECRYPT, KAT_CT_LOW, KAT_CT_HIGH, KAT_PT_LOW, KAT_PT_HIGH);
    // Writes to indexes that do not exist must leave the key alone
    add_key(REG_UNUSED_FIRST, '1);
    add_key(REG_UNUSED_LAST, 64'h0123456789abcdef);
    add_known(OP_ENCRYPT, KAT_PT_LOW, KAT_PT_HIGH, KAT_CT_LOW, KAT_CT_HIGH);
    // All-ones key
    add_key(REG_KEY_LOW, '1);
    add_key(REG_KEY_HIGH, '1);
    add_block(OP_ENCRYPT, '0, '0);
    add_block(OP_ENCRYPT, '1, '1);
    add_block(OP_DECRYPT, '0, '0);
    add_block(OP_DECRYPT, '1, '1);
    add_block(OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    // Mixed key halves, then back to zero
    add_key(REG_KEY_LOW, '0);
    add_block(OP_ENCRYPT, '0, '0);
    add_block(OP_DECRYPT, '1, '1);
    add_key(REG_KEY_HIGH, '0);
    add_block(OP_ENCRYPT, '0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the table back to back. The schedule pass after reset shows up
    // as busy and not ready, so the handshakes simply wait it out.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_KEY) begin
        settle();
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_block(directed_rows[i].blk, directed_rows[i].typed,
                   directed_rows[i].want, pred);
      end
    end

    // Random phases. Phases one and two pin the key to all ones and all
    // zeros; the rest may rewrite either key half with a random word.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        1: begin
          write_reg(REG_KEY_LOW, '1);
          write_reg(REG_KEY_HIGH, '1);
        end
        2: begin
          write_reg(REG_KEY_LOW, '0);
          write_reg(REG_KEY_HIGH, '0);
        end
        default: begin
          if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_LOW, pick_word());
          if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_HIGH, pick_word());
        end
      endcase
      // now and then a write that must be dropped
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(2, 255)), pick_word());
      have_prev = 1'b0;

      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        // Bursts of random length; the gaps before them land on any round
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        // A quarter of the time, feed the last answer back the other way
        if (have_prev && $urandom_range(0, 3) == 0) begin
          blk = '{op: ~prev_blk.op, block_low: prev_pred.result_low,
                  block_high: prev_pred.result_high};
          n_round_trips++;
        end else begin
          blk = '{op: 1'($urandom_range(0, 1)), block_low: pick_word(),
                  block_high: pick_word()};
        end
        send_block(blk, 1'b0, '0, pred);
        prev_blk  = blk;
        prev_pred = pred;
        have_prev = 1'b1;
        burst_left--;
      end
    end

    // Drain, then give the block time to show anything stray
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Processed %0d blocks: %0d encrypt, %0d decrypt, %0d fed back in reverse",
             n_encrypt + n_decrypt, n_encrypt, n_decrypt, n_round_trips);
    $display("Key register writes taken: %0d, over %0d random phases",
             n_key_loads, PHASES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
